// ===== sv/dfa_string_acceptor_top_assert.svh =====
// assertion macros for the dfa acceptor
`ifndef DFA_STRING_ACCEPTOR_TOP_ASSERT_SVH
`define DFA_STRING_ACCEPTOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define DFA_SA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define DFA_SA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DFA_SA_ASSERT(lbl, prop, msg)

`define DFA_SA_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ===== sv/dfa_sa_pkg.sv =====
package dfa_sa_pkg;

    localparam int unsigned MAX_STATES_DEF  = 16;
    localparam int unsigned SYMBOL_BITS_DEF = 8;
    localparam int unsigned CFG_INDEX_W     = 4;
    localparam int unsigned CFG_DATA_W      = 5;

    typedef enum logic [1:0] {
        MODE_WR_TRANS  = 2'd0,
        MODE_WR_ACCEPT = 2'd1,
        MODE_SYMBOL    = 2'd2,
        MODE_END       = 2'd3
    } mode_e;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_STATE = 4'd0,
        CFG_STATE_COUNT = 4'd1
    } cfg_reg_e;

    typedef struct packed {
        mode_e       mode;
        logic [3:0]  state_index;
        logic [7:0]  symbol;
        logic [3:0]  target_state;
        logic        entry_valid;
        logic        accept_flag;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  final_state;
        logic        stopped_early;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [3:0]  next;
    } tbl_entry_t;

    typedef struct packed {
        logic        wr;
        logic        rd;
        tbl_entry_t  data;
    } tbl_req_t;

endpackage

// ===== sv/dfa_sa_if.sv =====
interface dfa_sa_item_if;
    logic                valid;
    logic                ready;
    dfa_sa_pkg::item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dfa_sa_result_if;
    logic                valid;
    logic                ready;
    dfa_sa_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dfa_sa_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dfa_sa_pkg::CFG_INDEX_W-1:0] index;
    logic [dfa_sa_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/dfa_string_acceptor_top.sv =====
// channel  | dir | payload                                      | accepted when
// item     | in  | mode, state_index, symbol, target, valid, flag | valid && ready
// result   | out | accepted, final_state, stopped_early           | valid && ready
// cfg      | in  | index, data (start_state, state_count)         | valid && ready
//
// symbol items wait in stage 1 until the next state comes back from the registered
// table ram read, and the following item waits for them
// table writes, flag writes and end items let the following item in behind them
// an end item waits in its stage while the result register is full and not taken
// after reset the table ram is swept clear, all MAX_STATES << SYMBOL_BITS entries
// (4096 by default), with item.ready low; cfg is always ready
`include "dfa_string_acceptor_top_assert.svh"

module dfa_string_acceptor_top #(
    parameter int unsigned MAX_STATES  = dfa_sa_pkg::MAX_STATES_DEF,
    parameter int unsigned SYMBOL_BITS = dfa_sa_pkg::SYMBOL_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    dfa_sa_item_if.sink             item,
    dfa_sa_result_if.source         result,
    dfa_sa_cfg_if.sink              cfg
);

    localparam int unsigned SW = $clog2(MAX_STATES);
    localparam int unsigned AW = SW + SYMBOL_BITS;

    function automatic logic state_defined(input logic [3:0] s, input logic [4:0] cnt);
        state_defined = (5'(s) < cnt) && (32'(s) < 32'(MAX_STATES));
    endfunction

    // configuration
    logic [3:0] start_state_reg;
    logic [4:0] state_count_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= '0;
            state_count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                dfa_sa_pkg::CFG_START_STATE: start_state_reg <= cfg.data[3:0];
                dfa_sa_pkg::CFG_STATE_COUNT: state_count_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // run state
    logic [3:0]            cur_reg;
    logic [3:0]            cur_next;
    logic                  dead_reg;
    logic                  dead_next;
    logic                  fresh_reg;
    logic                  fresh_next;
    logic [MAX_STATES-1:0] flags_reg;
    logic [MAX_STATES-1:0] flags_next;

    // stage 1
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    dfa_sa_pkg::mode_e     s1_mode_reg;
    logic [3:0]            s1_sidx_reg;
    logic                  s1_flag_reg;
    logic [3:0]            s1_cur_reg;
    logic                  s1_retire;

    // result register
    logic                  res_valid_reg;
    logic                  res_valid_next;
    dfa_sa_pkg::result_t   res_data_reg;
    dfa_sa_pkg::result_t   res_data;
    logic                  res_load;

    // table ram
    dfa_sa_pkg::tbl_req_t   tbl_req;
    dfa_sa_pkg::tbl_entry_t tbl_rdata;
    logic [AW-1:0]          tbl_addr;
    logic                   tbl_busy;

    logic                   item_fire;
    logic [3:0]             run_fwd;
    logic [3:0]             res_cur;

    dfa_sa_table #(
        .MAX_STATES  (MAX_STATES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .addr  (tbl_addr),
        .rdata (tbl_rdata),
        .busy  (tbl_busy)
    );

    assign s1_retire = s1_valid_reg &&
                       ((s1_mode_reg != dfa_sa_pkg::MODE_END) || !res_valid_reg || result.ready);

    assign item.ready = !tbl_busy &&
                        !(s1_valid_reg && (s1_mode_reg == dfa_sa_pkg::MODE_SYMBOL)) &&
                        (!s1_valid_reg || s1_retire);

    assign item_fire = item.valid && item.ready;

    // an end item ahead resets the run before this one reads
    always_comb
    begin
        if (s1_valid_reg && (s1_mode_reg == dfa_sa_pkg::MODE_END))
        begin
            run_fwd = start_state_reg;
        end
        else if (fresh_reg)
        begin
            run_fwd = start_state_reg;
        end
        else
        begin
            run_fwd = cur_reg;
        end
    end

    always_comb
    begin
        if (item.data.mode == dfa_sa_pkg::MODE_SYMBOL)
        begin
            tbl_addr = {SW'(run_fwd), item.data.symbol[SYMBOL_BITS-1:0]};
        end
        else
        begin
            tbl_addr = {SW'(item.data.state_index), item.data.symbol[SYMBOL_BITS-1:0]};
        end
        tbl_req.wr = item_fire && (item.data.mode == dfa_sa_pkg::MODE_WR_TRANS) &&
                     (32'(item.data.state_index) < 32'(MAX_STATES));
        tbl_req.rd = item_fire && (item.data.mode == dfa_sa_pkg::MODE_SYMBOL);
        tbl_req.data.valid = item.data.entry_valid;
        tbl_req.data.next  = item.data.entry_valid ? item.data.target_state : 4'd0;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_retire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // verdict of an end item
    always_comb
    begin
        res_cur = fresh_reg ? start_state_reg : cur_reg;
        if (state_count_reg == 5'd0)
        begin
            res_data.accepted      = 1'b0;
            res_data.final_state   = start_state_reg;
            res_data.stopped_early = 1'b0;
        end
        else
        begin
            res_data.accepted      = !dead_reg && state_defined(res_cur, state_count_reg) &&
                                     flags_reg[SW'(res_cur)];
            res_data.final_state   = res_cur;
            res_data.stopped_early = dead_reg;
        end
    end

    assign res_load = s1_retire && (s1_mode_reg == dfa_sa_pkg::MODE_END);

    always_comb
    begin
        cur_next   = cur_reg;
        dead_next  = dead_reg;
        fresh_next = fresh_reg;
        flags_next = flags_reg;
        if (s1_retire)
        begin
            unique case (s1_mode_reg)
                dfa_sa_pkg::MODE_WR_TRANS:
                begin
                end
                dfa_sa_pkg::MODE_WR_ACCEPT:
                begin
                    if (32'(s1_sidx_reg) < 32'(MAX_STATES))
                    begin
                        flags_next[SW'(s1_sidx_reg)] = s1_flag_reg;
                    end
                end
                dfa_sa_pkg::MODE_SYMBOL:
                begin
                    if ((state_count_reg != 5'd0) && !dead_reg)
                    begin
                        cur_next   = s1_cur_reg;
                        fresh_next = 1'b0;
                        if (!state_defined(s1_cur_reg, state_count_reg))
                        begin
                            dead_next = 1'b1;
                        end
                        else if (tbl_rdata.valid &&
                                 state_defined(tbl_rdata.next, state_count_reg))
                        begin
                            cur_next = tbl_rdata.next;
                        end
                        else
                        begin
                            dead_next = 1'b1;
                        end
                    end
                end
                dfa_sa_pkg::MODE_END:
                begin
                    cur_next   = start_state_reg;
                    dead_next  = 1'b0;
                    fresh_next = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            dead_reg      <= 1'b0;
            fresh_reg     <= 1'b1;
            flags_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            dead_reg      <= dead_next;
            fresh_reg     <= fresh_next;
            flags_reg     <= flags_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_mode_reg <= item.data.mode;
            s1_sidx_reg <= item.data.state_index;
            s1_flag_reg <= item.data.accept_flag;
            s1_cur_reg  <= run_fwd;
        end
        if (res_load)
        begin
            res_data_reg <= res_data;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    `DFA_SA_ASSERT_RST(a_no_request_while_clearing, tbl_busy |-> !item.ready, "request taken during table clear")
    `DFA_SA_ASSERT(a_symbol_interlock, (s1_valid_reg && (s1_mode_reg == dfa_sa_pkg::MODE_SYMBOL)) |-> !item.ready, "request taken behind pending table read")
    `DFA_SA_ASSERT(a_end_restarts_run, res_load |=> (result.valid && fresh_reg && !dead_reg), "end of string did not post result and restart")
    `DFA_SA_ASSERT(a_dead_from_symbol, $rose(dead_reg) |-> $past(s1_valid_reg && (s1_mode_reg == dfa_sa_pkg::MODE_SYMBOL)), "run stopped without a symbol")

endmodule

// ===== sv/dfa_sa_table.sv =====
module dfa_sa_table #(
    parameter int unsigned MAX_STATES  = dfa_sa_pkg::MAX_STATES_DEF,
    parameter int unsigned SYMBOL_BITS = dfa_sa_pkg::SYMBOL_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  dfa_sa_pkg::tbl_req_t                       req,
    input  logic [$clog2(MAX_STATES)+SYMBOL_BITS-1:0]  addr,
    output dfa_sa_pkg::tbl_entry_t                     rdata,
    output logic                                       busy
);

    localparam int unsigned AW    = $clog2(MAX_STATES) + SYMBOL_BITS;
    localparam int unsigned DEPTH = MAX_STATES * (1 << SYMBOL_BITS);

    dfa_sa_pkg::tbl_entry_t mem [DEPTH];
    dfa_sa_pkg::tbl_entry_t rdata_reg;

    logic          busy_reg;
    logic          busy_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    // clearing sweep after reset
    always_comb
    begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (req.wr)
        begin
            mem[addr] <= req.data;
        end
        if (req.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

// ===== bench/dfa_verdict_checker.sv =====
`timescale 1ns / 100ps

module dfa_verdict_checker (
    input  logic        clk,
    input  logic        rst_n,
    dfa_sa_item_if      item,
    dfa_sa_result_if    result,
    dfa_sa_cfg_if       cfg,
    output int unsigned mismatches,
    output int unsigned pending
);
    import dfa_sa_pkg::*;

    logic       arc_ok [0:4095];
    logic [3:0] arc_to [0:4095];
    logic       accepting [0:15];
    logic [3:0] walk_state;
    logic       dead;
    logic       fresh;
    logic [3:0] start_st;
    logic [4:0] n_states;
    result_t    verdict_q [$];
    result_t    want;
    result_t    got;
    int unsigned errs;

    function automatic logic defined_state(input logic [3:0] s);
        return {1'b0, s} < n_states;
    endfunction

    task automatic apply_request(input item_t req);
        logic [11:0] addr;
        logic [3:0]  cur;
        result_t     v;
        cur = fresh ? start_st : walk_state;
        case (req.mode)
            MODE_WR_TRANS:
            begin
                addr = {req.state_index, req.symbol};
                arc_ok[addr] = req.entry_valid;
                arc_to[addr] = req.entry_valid ? req.target_state : 4'd0;
            end
            MODE_WR_ACCEPT:
            begin
                accepting[req.state_index] = req.accept_flag;
            end
            MODE_SYMBOL:
            begin
                if (n_states != 0 && !dead)
                begin
                    walk_state = cur;
                    fresh = 1'b0;
                    if (!defined_state(cur))
                        dead = 1'b1;
                    else
                    begin
                        addr = {cur, req.symbol};
                        if (arc_ok[addr] && defined_state(arc_to[addr]))
                            walk_state = arc_to[addr];
                        else
                            dead = 1'b1;
                    end
                end
            end
            MODE_END:
            begin
                v.accepted = (n_states != 0) && !dead && defined_state(cur) && accepting[cur];
                v.final_state = (n_states == 0) ? start_st : cur;
                v.stopped_early = (n_states != 0) && dead;
                verdict_q = {verdict_q, v};
                walk_state = start_st;
                dead = 1'b0;
                fresh = 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4096; i++)
            begin
                arc_ok[i] = 1'b0;
                arc_to[i] = 4'd0;
            end
            for (int i = 0; i < 16; i++)
                accepting[i] = 1'b0;
            walk_state = 4'd0;
            dead = 1'b0;
            fresh = 1'b1;
            start_st = 4'd0;
            n_states = 5'd0;
            errs = 0;
            verdict_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_START_STATE: start_st = cfg.data[3:0];
                    CFG_STATE_COUNT: n_states = cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            if (item.valid && item.ready)
                apply_request(item.data);
            if (result.valid && result.ready)
            begin
                got = result.data;
                if (verdict_q.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected verdict: acc=%0d final=%0d stop=%0d",
                                 got.accepted, got.final_state, got.stopped_early);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (got.accepted !== want.accepted
                        || got.final_state !== want.final_state
                        || got.stopped_early !== want.stopped_early)
                    begin
                        errs++;
                        if (errs <= 10)
                        begin
                            $display("verdict mismatch: expected acc=%0d final=%0d stop=%0d",
                                     want.accepted, want.final_state, want.stopped_early);
                            $display("                  got acc=%0d final=%0d stop=%0d",
                                     got.accepted, got.final_state, got.stopped_early);
                        end
                    end
                end
            end
        end
        mismatches <= errs;
        pending <= verdict_q.size();
    end
endmodule

// ===== bench/tb_dfa_string_acceptor_top.sv =====
`timescale 1ns / 100ps

module tb_dfa_string_acceptor_top;
    import dfa_sa_pkg::*;

    localparam int unsigned STALL_LIMIT  = 20000;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned mismatches;
    int unsigned pending;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned requests_sent = 0;
    int unsigned quiet_cycles = 0;
    logic [7:0]  alphabet [0:3];

    dfa_sa_item_if   item_ch ();
    dfa_sa_result_if result_ch ();
    dfa_sa_cfg_if    cfg_ch ();

    dfa_string_acceptor_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    dfa_verdict_checker u_verdict_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("dfa_string_acceptor_top test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_request(input mode_e m, input logic [3:0] sidx, input logic [7:0] sym,
                                input logic [3:0] tgt, input logic ev, input logic af);
        item_t req;
        req.mode = m;
        req.state_index = sidx;
        req.symbol = sym;
        req.target_state = tgt;
        req.entry_valid = ev;
        req.accept_flag = af;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data <= req;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic wait_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic cfg_handshake();
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [3:0] st, input logic [4:0] cnt);
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_START_STATE;
        cfg_ch.data <= {1'($urandom_range(0, 1)), st};
        cfg_handshake();
        if (requests_sent == 0 || $urandom_range(0, 3) == 0)
        begin
            cfg_ch.index <= CFG_INDEX_W'($urandom_range(2, 15));
            cfg_ch.data <= CFG_DATA_W'($urandom);
            cfg_handshake();
        end
        cfg_ch.index <= CFG_STATE_COUNT;
        cfg_ch.data <= cnt;
        cfg_handshake();
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned budget, input logic [3:0] st,
                             input logic [4:0] cnt);
        int unsigned stop_at;
        int unsigned live;
        int unsigned len;
        logic [7:0]  sym;
        program_regs(st, cnt);
        live = (cnt > 16) ? 16 : cnt;
        for (int k = 0; k < 4; k++)
            alphabet[k] = 8'($urandom);
        stop_at = requests_sent + budget;
        // well-formed automaton over a small alphabet, a few arcs missing or dangling
        for (int s = 0; s < live; s++)
        begin
            send_request(MODE_WR_ACCEPT, 4'(s), 8'($urandom), 4'($urandom), 1'($urandom),
                         1'($urandom));
            for (int k = 0; k < 4; k++)
                send_request(MODE_WR_TRANS, 4'(s), alphabet[k], 4'($urandom_range(0, live)),
                             ($urandom_range(0, 99) < 88), 1'($urandom));
        end
        while (requests_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                sym = ($urandom_range(0, 1) == 1) ? alphabet[$urandom_range(0, 3)]
                                                  : 8'($urandom);
                send_request(mode_e'($urandom_range(0, 3)), 4'($urandom), sym, 4'($urandom),
                             1'($urandom), 1'($urandom));
            end
            else
            begin
                len = $urandom_range(0, 8);
                for (int j = 0; j < len; j++)
                begin
                    sym = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                      : alphabet[$urandom_range(0, 3)];
                    send_request(MODE_SYMBOL, 4'($urandom), sym, 4'($urandom), 1'($urandom),
                                 1'($urandom));
                end
                send_request(MODE_END, 4'($urandom), 8'($urandom), 4'($urandom), 1'($urandom),
                             1'($urandom));
                if ($urandom_range(0, 99) < 2)
                    wait_results();
            end
        end
    endtask

    task automatic set_idling(input int unsigned mode_sel);
        case (mode_sel)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 86;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 86;
            end
            default:
            begin
                send_idle_pct = 15;
                recv_stall_pct = 15;
            end
        endcase
    endtask

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_START_STATE;
        cfg_ch.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // no states defined
        program_regs(4'd3, 5'd0);
        send_request(MODE_END, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        send_request(MODE_SYMBOL, 4'd0, 8'hff, 4'd0, 1'b0, 1'b0);
        send_request(MODE_END, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);

        program_regs(4'd0, 5'd16);
        send_request(MODE_WR_ACCEPT, 4'd15, 8'd0, 4'd0, 1'b0, 1'b1);
        send_request(MODE_WR_ACCEPT, 4'd0, 8'd0, 4'd0, 1'b0, 1'b1);
        send_request(MODE_WR_TRANS, 4'd0, 8'hff, 4'd15, 1'b1, 1'b0);
        send_request(MODE_WR_TRANS, 4'd15, 8'h00, 4'd0, 1'b1, 1'b0);
        send_request(MODE_END, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        send_request(MODE_SYMBOL, 4'd0, 8'hff, 4'd0, 1'b0, 1'b0);
        send_request(MODE_END, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        // two arcs followed, then a missing arc, then an ignored symbol while dead
        send_request(MODE_SYMBOL, 4'd0, 8'hff, 4'd0, 1'b0, 1'b0);
        send_request(MODE_SYMBOL, 4'd0, 8'h00, 4'd0, 1'b0, 1'b0);
        send_request(MODE_SYMBOL, 4'd0, 8'h00, 4'd0, 1'b0, 1'b0);
        send_request(MODE_SYMBOL, 4'd0, 8'hff, 4'd0, 1'b0, 1'b0);
        send_request(MODE_END, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        // removed arc
        send_request(MODE_WR_TRANS, 4'd0, 8'hff, 4'd15, 1'b0, 1'b0);
        send_request(MODE_SYMBOL, 4'd0, 8'hff, 4'd0, 1'b0, 1'b0);
        send_request(MODE_END, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);

        // arc into an undefined state
        program_regs(4'd1, 5'd2);
        send_request(MODE_WR_TRANS, 4'd1, 8'd7, 4'd9, 1'b1, 1'b0);
        send_request(MODE_SYMBOL, 4'd0, 8'd7, 4'd0, 1'b0, 1'b0);
        send_request(MODE_END, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);

        // start state outside the defined range
        program_regs(4'd5, 5'd2);
        send_request(MODE_WR_ACCEPT, 4'd5, 8'd0, 4'd0, 1'b0, 1'b1);
        send_request(MODE_END, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        send_request(MODE_SYMBOL, 4'd0, 8'd7, 4'd0, 1'b0, 1'b0);
        send_request(MODE_END, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);

        set_idling(0);
        run_phase(250, 4'd0, 5'd16);
        set_idling(1);
        run_phase(250, 4'd15, 5'd31);
        set_idling(2);
        run_phase(250, 4'($urandom), 5'd1);
        set_idling(3);
        run_phase(100, 4'($urandom), 5'd0);
        set_idling(0);
        run_phase(250, 4'($urandom), 5'($urandom_range(2, 15)));
        set_idling(1);
        run_phase(250, 4'd15, 5'd16);
        set_idling(2);
        run_phase(250, 4'($urandom), 5'($urandom_range(0, 16)));
        set_idling(3);
        run_phase(250, 4'd0, 5'd2);

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("dfa_string_acceptor_top test passed");
        else
            $display("dfa_string_acceptor_top test failed");
        $finish;
    end
endmodule
